>>> src/hkad_pkg.sv
// shared types, codes and string tables of the http keep-alive decider
package hkad_pkg;

   localparam logic [1:0] KIND_METHOD  = 2'd0;
   localparam logic [1:0] KIND_VERSION = 2'd1;
   localparam logic [1:0] KIND_HEADER  = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   localparam logic [15:0] LIMIT_RESET = 16'd100;

   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   localparam logic [7:0] CHAR_V11_LAST = 8'h31;
   localparam logic [7:0] CHAR_V10_LAST = 8'h30;

   typedef struct packed {
      logic keep_alive;
      logic close_token_seen;
      logic keepalive_token_seen;
   } result_type;

   function automatic logic [7:0] get_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h47;
         2'd1: c = 8'h45;
         2'd2: c = 8'h54;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] head_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h48;
         2'd1: c = 8'h45;
         2'd2: c = 8'h41;
         default: c = 8'h44;
      endcase
      return c;
   endfunction

   // common prefix of both version strings, last byte handled separately
   function automatic logic [7:0] version_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h48;
         3'd1: c = 8'h54;
         3'd2: c = 8'h54;
         3'd3: c = 8'h50;
         3'd4: c = 8'h2f;
         3'd5: c = 8'h31;
         3'd6: c = 8'h2e;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] close_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h63;
         3'd1: c = 8'h6c;
         3'd2: c = 8'h6f;
         3'd3: c = 8'h73;
         3'd4: c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] keep_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = 8'h6b;
         4'd1: c = 8'h65;
         4'd2: c = 8'h65;
         4'd3: c = 8'h70;
         4'd4: c = 8'h2d;
         4'd5: c = 8'h61;
         4'd6: c = 8'h6c;
         4'd7: c = 8'h69;
         4'd8: c = 8'h76;
         4'd9: c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> src/hkad_tracker.sv
// per-request match state and decision logic of the http keep-alive decider
module hkad_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [1:0]             kind,
   input  logic [7:0]             data_byte,
   input  logic                   has_body,
   input  logic [15:0]            served_count,
   input  logic [15:0]            request_limit,
   output hkad_pkg::result_type   result
);
   import hkad_pkg::*;

   typedef enum logic [1:0] {
      PHASE_LEAD  = 2'd0,
      PHASE_TOKEN = 2'd1,
      PHASE_TRAIL = 2'd2
   } phase_type;

   typedef struct packed {
      logic [2:0] method_length;
      logic       method_get_match;
      logic       method_head_match;
      logic [3:0] version_length;
      logic       version_11_match;
      logic       version_10_match;
      phase_type  part_phase;
      logic [3:0] token_length;
      logic       part_close_match;
      logic       part_keepalive_match;
      logic       close_found;
      logic       keepalive_found;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      method_length:        3'd0,
      method_get_match:     1'b1,
      method_head_match:    1'b1,
      version_length:       4'd0,
      version_11_match:     1'b1,
      version_10_match:     1'b1,
      part_phase:           PHASE_LEAD,
      token_length:         4'd0,
      part_close_match:     1'b1,
      part_keepalive_match: 1'b1,
      close_found:          1'b0,
      keepalive_found:      1'b0
   };

   state_type  state_ff;
   state_type  state_in;
   logic       close_fin;
   logic       keep_fin;
   logic       method_ok;
   logic       version_ok;
   logic       v11_ok;
   logic       v10_ok;
   logic [7:0] lower_byte;
   logic       part_live;
   logic [7:0] v11_exp;
   logic [7:0] v10_exp;

   // flags as they stand once the open part is closed
   assign close_fin = state_ff.close_found |
                      ((state_ff.part_phase != PHASE_LEAD) && state_ff.part_close_match &&
                       (state_ff.token_length == 4'd5));
   assign keep_fin  = state_ff.keepalive_found |
                      ((state_ff.part_phase != PHASE_LEAD) && state_ff.part_keepalive_match &&
                       (state_ff.token_length == 4'd10));

   assign method_ok = (state_ff.method_get_match && (state_ff.method_length == 3'd3)) ||
                      (state_ff.method_head_match && (state_ff.method_length == 3'd4));
   assign v11_ok    = state_ff.version_11_match && (state_ff.version_length == 4'd8);
   assign v10_ok    = state_ff.version_10_match && (state_ff.version_length == 4'd8);
   assign version_ok = v11_ok || (v10_ok && keep_fin);

   assign result.keep_alive = method_ok && !has_body && (served_count < request_limit) &&
                              !close_fin && version_ok;
   assign result.close_token_seen     = close_fin;
   assign result.keepalive_token_seen = keep_fin;

   assign lower_byte = ((data_byte >= 8'h41) && (data_byte <= 8'h5a)) ?
                       (data_byte + 8'd32) : data_byte;
   assign part_live  = state_ff.part_phase != PHASE_TRAIL;

   assign v11_exp = (state_ff.version_length[2:0] == 3'd7) ? CHAR_V11_LAST :
                    version_char(state_ff.version_length[2:0]);
   assign v10_exp = (state_ff.version_length[2:0] == 3'd7) ? CHAR_V10_LAST :
                    version_char(state_ff.version_length[2:0]);

   always_comb begin
      state_in = state_ff;
      if (step) begin
         case (kind)
            KIND_METHOD: begin
               state_in.method_get_match = state_ff.method_get_match &&
                  (state_ff.method_length < 3'd3) &&
                  (data_byte == get_char(state_ff.method_length[1:0]));
               state_in.method_head_match = state_ff.method_head_match &&
                  (state_ff.method_length < 3'd4) &&
                  (data_byte == head_char(state_ff.method_length[1:0]));
               if (state_ff.method_length != 3'd7) begin
                  state_in.method_length = state_ff.method_length + 3'd1;
               end
            end
            KIND_VERSION: begin
               state_in.version_11_match = state_ff.version_11_match &&
                  (state_ff.version_length < 4'd8) && (data_byte == v11_exp);
               state_in.version_10_match = state_ff.version_10_match &&
                  (state_ff.version_length < 4'd8) && (data_byte == v10_exp);
               if (state_ff.version_length != 4'd15) begin
                  state_in.version_length = state_ff.version_length + 4'd1;
               end
            end
            KIND_HEADER: begin
               if (data_byte == CHAR_COMMA) begin
                  state_in.close_found          = close_fin;
                  state_in.keepalive_found      = keep_fin;
                  state_in.part_phase           = PHASE_LEAD;
                  state_in.token_length         = 4'd0;
                  state_in.part_close_match     = 1'b1;
                  state_in.part_keepalive_match = 1'b1;
               end else if ((data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB)) begin
                  if (state_ff.part_phase == PHASE_TOKEN) begin
                     state_in.part_phase = PHASE_TRAIL;
                  end
               end else begin
                  state_in.part_close_match = state_ff.part_close_match && part_live &&
                     (state_ff.token_length < 4'd5) &&
                     (lower_byte == close_char(state_ff.token_length[2:0]));
                  state_in.part_keepalive_match = state_ff.part_keepalive_match &&
                     part_live && (state_ff.token_length < 4'd10) &&
                     (lower_byte == keep_char(state_ff.token_length));
                  if (state_ff.token_length != 4'd15) begin
                     state_in.token_length = state_ff.token_length + 4'd1;
                  end
                  state_in.part_phase = PHASE_TOKEN;
               end
            end
            default: begin
               state_in = STATE_CLEAR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/http_keep_alive_decider.sv
// top level of the http keep-alive decider: input stage, result register, csr
// usage:
//   req channel (valid/ready) carries one tagged byte of the method, version or
//   connection header per transaction, or an end-of-request transaction that
//   carries has_body and served_count. bytes of the three strings may interleave.
//   rsp channel (valid/ready) carries one decision per end-of-request transaction
//   and nothing for byte transactions.
//   an accepted transaction is held in the input register until it advances, and is
//   folded into the match state as it leaves; an end transaction loads its decision
//   into the result register as it advances, where it stays on rsp until taken. one
//   transaction per cycle is sustained unless an end waits on a stalled rsp; the
//   single byte-compare-and-update step lies between input and result registers.
//   csr register 0 at byte address 0 holds request_limit (reset 100); write it
//   only while the block is idle.
//   reset clears the match state and both stages and sets request_limit to 100.
//   when rsp is stalled, byte transactions keep flowing; an end transaction waits
//   in the input register until the result register frees, with req_ready low.
module http_keep_alive_decider (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_body,
   input  logic [15:0] req_served_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_keep_alive,
   output logic        rsp_close_token_seen,
   output logic        rsp_keepalive_token_seen,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import hkad_pkg::*;

   logic        stage_valid_ff;
   logic [1:0]  stage_type_ff;
   logic [7:0]  stage_byte_ff;
   logic        stage_body_ff;
   logic [15:0] stage_served_ff;
   logic        rsp_valid_ff;
   result_type  rsp_result_ff;
   logic [15:0] limit_ff;
   logic        advance;
   logic        stage_is_end;
   logic        csr_write;
   result_type  result;

   assign stage_is_end = stage_type_ff == KIND_END;
   assign advance   = stage_valid_ff && (!stage_is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata    = (paddr[2] == 1'b0) ? {16'd0, limit_ff} : 32'd0;

   hkad_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .kind          (stage_type_ff),
      .data_byte     (stage_byte_ff),
      .has_body      (stage_body_ff),
      .served_count  (stage_served_ff),
      .request_limit (limit_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         limit_ff       <= LIMIT_RESET;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance && stage_is_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            limit_ff <= pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_type_ff   <= req_type;
         stage_byte_ff   <= req_data_byte;
         stage_body_ff   <= req_has_body;
         stage_served_ff <= req_served_count;
      end
      if (advance && stage_is_end) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_keep_alive           = rsp_result_ff.keep_alive;
   assign rsp_close_token_seen     = rsp_result_ff.close_token_seen;
   assign rsp_keepalive_token_seen = rsp_result_ff.keepalive_token_seen;

   // a close token always forces the connection closed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_result_ff.keep_alive && rsp_result_ff.close_token_seen))
      else $error("keep_alive reported together with a close token");

   // an end transaction that advances always loads a decision
   assert property (@(posedge clock) disable iff (reset)
      (advance && stage_is_end) |=> rsp_valid_ff)
      else $error("end transaction advanced without a decision");

   // byte transactions never create a decision
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_is_end) |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready)))
      else $error("byte transaction changed the result register");

   // an end transaction never overwrites a pending decision
   assert property (@(posedge clock) disable iff (reset)
      (advance && stage_is_end) |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending decision overwritten");

endmodule

>>> tb/tb.sv
// self-checking testbench of the http keep-alive decider
`timescale 1ns / 100ps

module tb;
   import hkad_pkg::*;

   localparam logic [2:0] ADDR_LIMIT  = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS = 250;

   localparam logic [79:0] TXT_GET   = "GET";
   localparam logic [79:0] TXT_HEAD  = "HEAD";
   localparam logic [79:0] TXT_V11   = "HTTP/1.1";
   localparam logic [79:0] TXT_V10   = "HTTP/1.0";
   localparam logic [79:0] TXT_CLOSE = "close";
   localparam logic [79:0] TXT_KEEP  = "keep-alive";

   typedef enum logic [1:0] {PART_LEAD, PART_TOKEN, PART_TRAIL} part_phase_type;

   function automatic logic [7:0] text_char(input logic [79:0] txt, input int n, input int p);
      if (p >= n) begin
         return 8'h00;
      end
      return txt[8*(n-1-p) +: 8];
   endfunction

   class keep_alive_scoreboard;
      logic [15:0] limit;
      logic [2:0]  method_len;
      logic        get_ok, head_ok;
      logic [3:0]  version_len;
      logic        v11_ok, v10_ok;
      part_phase_type phase;
      logic [3:0]  token_len;
      logic        part_close, part_keep;
      logic        close_seen, keepalive_seen;
      result_type  decisions_due[$];
      int          errors;

      function new();
         limit = LIMIT_RESET;
         errors = 0;
         clear_request();
      endfunction

      function void set_limit(input logic [15:0] value);
         limit = value;
      endfunction

      function void open_part();
         phase = PART_LEAD;
         token_len = 4'd0;
         part_close = 1'b1;
         part_keep = 1'b1;
      endfunction

      function void clear_request();
         method_len = 3'd0;
         get_ok = 1'b1;
         head_ok = 1'b1;
         version_len = 4'd0;
         v11_ok = 1'b1;
         v10_ok = 1'b1;
         open_part();
         close_seen = 1'b0;
         keepalive_seen = 1'b0;
      endfunction

      function void close_part();
         if (phase != PART_LEAD) begin
            if (part_close && token_len == 4'd5) close_seen = 1'b1;
            if (part_keep && token_len == 4'd10) keepalive_seen = 1'b1;
         end
         open_part();
      endfunction

      function void fold_header(input logic [7:0] b);
         logic [7:0] lc;
         int p;
         if (b == CHAR_COMMA) begin
            close_part();
         end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
            if (phase == PART_TOKEN) phase = PART_TRAIL;
         end else begin
            if (phase == PART_TRAIL) begin
               part_close = 1'b0;
               part_keep = 1'b0;
            end
            lc = (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
            p = token_len;
            part_close = part_close && p < 5 && lc == text_char(TXT_CLOSE, 5, p);
            part_keep = part_keep && p < 10 && lc == text_char(TXT_KEEP, 10, p);
            if (token_len != 4'd15) token_len++;
            phase = PART_TOKEN;
         end
      endfunction

      function void absorb_item(input logic [1:0] kind, input logic [7:0] b,
                                input logic body, input logic [15:0] served);
         result_type decision;
         logic method_ok;
         int p;
         case (kind)
            KIND_METHOD: begin
               p = method_len;
               get_ok = get_ok && p < 3 && b == text_char(TXT_GET, 3, p);
               head_ok = head_ok && p < 4 && b == text_char(TXT_HEAD, 4, p);
               if (method_len != 3'd7) method_len++;
            end
            KIND_VERSION: begin
               p = version_len;
               v11_ok = v11_ok && p < 8 && b == text_char(TXT_V11, 8, p);
               v10_ok = v10_ok && p < 8 && b == text_char(TXT_V10, 8, p);
               if (version_len != 4'd15) version_len++;
            end
            KIND_HEADER: begin
               fold_header(b);
            end
            KIND_END: begin
               close_part();
               method_ok = (get_ok && method_len == 3'd3) || (head_ok && method_len == 3'd4);
               decision.keep_alive = 1'b0;
               if (method_ok && !body && served < limit && !close_seen) begin
                  if (v11_ok && version_len == 4'd8) decision.keep_alive = 1'b1;
                  else if (v10_ok && version_len == 4'd8) decision.keep_alive = keepalive_seen;
               end
               decision.close_token_seen = close_seen;
               decision.keepalive_token_seen = keepalive_seen;
               decisions_due.push_back(decision);
               clear_request();
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_bit(input string field, input logic want, input logic got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_decision(input result_type got);
         result_type want;
         if (decisions_due.size() == 0) begin
            $display("%0t: unexpected decision, expected none actual %b", $time, got);
            errors++;
            return;
         end
         want = decisions_due.pop_front();
         compare_bit("keep_alive", want.keep_alive, got.keep_alive);
         compare_bit("close_token_seen", want.close_token_seen, got.close_token_seen);
         compare_bit("keepalive_token_seen", want.keepalive_token_seen,
                     got.keepalive_token_seen);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [7:0]  req_data_byte;
   logic        req_has_body;
   logic [15:0] req_served_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_keep_alive;
   logic        rsp_close_token_seen;
   logic        rsp_keepalive_token_seen;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   keep_alive_scoreboard sb = new();

   logic [7:0] text[$];
   logic [7:0] method_q[$];
   logic [7:0] version_q[$];
   logic [7:0] header_q[$];
   bit steady;
   bit hold_off_due;
   int hold_left;
   int phase_items;
   int quiet;

   http_keep_alive_decider u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_data_byte(req_data_byte),
      .req_has_body(req_has_body),
      .req_served_count(req_served_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_keep_alive(rsp_keep_alive),
      .rsp_close_token_seen(rsp_close_token_seen),
      .rsp_keepalive_token_seen(rsp_keepalive_token_seen),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      if (hold_off_due) begin
         hold_left = HOLD_CYCLES;
         hold_off_due = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = steady || ($urandom_range(99) >= 21);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_decision({rsp_keep_alive, rsp_close_token_seen, rsp_keepalive_token_seen});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("http_keep_alive_decider verification failed");
            $finish;
         end
      end
   end

   function automatic void load_text(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic void random_text(input int n, input bit letters);
      text.delete();
      for (int i = 0; i < n; i++) begin
         text.push_back(letters ? 8'($urandom_range(8'h61, 8'h7a)) : 8'($urandom_range(255)));
      end
   endfunction

   function automatic void toggle_case();
      for (int i = 0; i < text.size(); i++) begin
         if (((text[i] | 8'h20) >= 8'h61) && ((text[i] | 8'h20) <= 8'h7a) && $urandom_range(1))
            text[i] = text[i] ^ 8'h20;
      end
   endfunction

   // corrupt a well-formed string in one of several ways
   function automatic void damage_text(input int extra_max);
      case ($urandom_range(4))
         0: if (text.size() > 0) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
         1: toggle_case();
         2: if (text.size() > 0) void'(text.pop_back());
         3: repeat ($urandom_range(1, extra_max)) text.push_back(8'($urandom_range(255)));
         default: text.insert($urandom_range(text.size()), $urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      endcase
   endfunction

   function automatic void build_method();
      int r;
      r = $urandom_range(99);
      if (r < 40) load_text("GET");
      else if (r < 75) load_text("HEAD");
      else if (r < 93) begin
         if ($urandom_range(1)) load_text("GET");
         else load_text("HEAD");
         damage_text(6);
      end else random_text($urandom_range(0, 10), 1'b0);
      method_q = text;
   endfunction

   function automatic void build_version();
      int r;
      r = $urandom_range(99);
      if (r < 40) load_text("HTTP/1.1");
      else if (r < 75) load_text("HTTP/1.0");
      else if (r < 93) begin
         if ($urandom_range(1)) load_text("HTTP/1.1");
         else load_text("HTTP/1.0");
         damage_text(9);
      end else random_text($urandom_range(0, 18), 1'b0);
      version_q = text;
   endfunction

   function automatic void add_blanks();
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 2)) header_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      end
   endfunction

   function automatic void build_header();
      int r;
      int parts;
      header_q.delete();
      parts = $urandom_range(0, 3);
      if ($urandom_range(9) == 0) header_q.push_back(CHAR_COMMA);
      for (int i = 0; i < parts; i++) begin
         if (i > 0) header_q.push_back(CHAR_COMMA);
         r = $urandom_range(99);
         if (r < 35) load_text("close");
         else if (r < 70) load_text("keep-alive");
         else if (r < 82) begin
            if ($urandom_range(1)) load_text("close");
            else load_text("keep-alive");
            damage_text(8);
         end else if (r < 87) random_text($urandom_range(12, 20), 1'b1);
         else if (r < 93) text.delete();
         else random_text($urandom_range(1, 6), 1'b0);
         if ($urandom_range(1)) toggle_case();
         add_blanks();
         foreach (text[j]) header_q.push_back(text[j]);
         add_blanks();
      end
      if ($urandom_range(9) == 0) header_q.push_back(CHAR_COMMA);
   endfunction

   function automatic logic [15:0] pick_served();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return sb.limit - 16'd1;
         2: return sb.limit;
         3: return sb.limit + 16'd1;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_item(input logic [1:0] kind, input logic [7:0] value,
                            input logic body, input logic [15:0] served);
      while (!steady && $urandom_range(99) < 21) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_data_byte = value;
      req_has_body = body;
      req_served_count = served;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.absorb_item(kind, value, body, served);
      phase_items++;
      @(negedge clock);
   endtask

   task automatic send_filler(input logic [1:0] kind, input logic [7:0] value);
      send_item(kind, value, 1'($urandom_range(1)), 16'($urandom_range(65535)));
   endtask

   task automatic send_fields();
      int pick;
      while (method_q.size() + version_q.size() + header_q.size() > 0) begin
         pick = $urandom_range(2);
         if (pick == 0 && method_q.size() > 0) send_filler(KIND_METHOD, method_q.pop_front());
         else if (pick == 1 && version_q.size() > 0) send_filler(KIND_VERSION, version_q.pop_front());
         else if (pick == 2 && header_q.size() > 0) send_filler(KIND_HEADER, header_q.pop_front());
      end
   endtask

   task automatic run_request();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 20)) send_filler(2'($urandom_range(2)), 8'($urandom_range(255)));
      end else begin
         build_method();
         build_version();
         build_header();
         send_fields();
      end
      send_item(KIND_END, 8'($urandom_range(255)), $urandom_range(99) < 15, pick_served());
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.decisions_due.size() != 0) @(negedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input bit pause_midway);
      bit paused;
      paused = 1'b0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
         run_request();
         if (pause_midway && !paused && phase_items > PHASE_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      settle();
   endtask

   task automatic csr_access(input logic [2:0] addr, input bit write, input logic [31:0] data);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = write;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (!write && prdata[15:0] !== sb.limit) begin
         $display("%0t: request_limit readback mismatch, expected %0h actual %0h",
                  $time, sb.limit, prdata[15:0]);
         sb.errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic write_limit(input logic [2:0] addr, input logic [15:0] value);
      csr_access(addr, 1'b1, {16'($urandom_range(65535)), value});
      if (addr == ADDR_LIMIT) sb.set_limit(value);
      csr_access(ADDR_LIMIT, 1'b0, 32'h0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = KIND_METHOD;
      req_data_byte = 8'h00;
      req_has_body = 1'b0;
      req_served_count = 16'h0000;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = ADDR_LIMIT;
      pwdata = 32'h0;
      steady = 1'b0;
      hold_off_due = 1'b0;
      hold_left = 0;
      quiet = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty request, all end fields at their top
      send_item(KIND_END, 8'hff, 1'b1, 16'hffff);
      // head over http/1.0 with a mixed case keep-alive token
      load_text("HEAD");
      method_q = text;
      load_text("HTTP/1.0");
      version_q = text;
      load_text("\tKEEP-alive ,");
      header_q = text;
      send_fields();
      send_item(KIND_END, 8'h00, 1'b0, 16'h0000);

      run_phase(1'b0);
      write_limit(ADDR_LIMIT, 16'hffff);
      run_phase(1'b0);
      write_limit(ADDR_LIMIT, 16'h0000);
      steady = 1'b1;
      run_phase(1'b0);
      steady = 1'b0;
      write_limit(ADDR_LIMIT, 16'h0001);
      hold_off_due = 1'b1;
      run_phase(1'b0);
      write_limit(ADDR_UNUSED, 16'($urandom_range(65535)));
      write_limit(ADDR_LIMIT, 16'($urandom_range(65535)));
      run_phase(1'b1);
      write_limit(ADDR_LIMIT, LIMIT_RESET);
      run_phase(1'b0);

      settle();
      if (sb.errors == 0) begin
         $display("http_keep_alive_decider verification clean");
      end else begin
         $display("http_keep_alive_decider verification failed");
      end
      $finish;
   end

endmodule
